// ----- src/cce_pkg.sv -----
// Shared codes and types for the controller change-event recorder.
`default_nettype none
package cce_pkg;

  localparam logic [1:0] CMD_START  = 2'd0;
  localparam logic [1:0] CMD_REPORT = 2'd1;
  localparam logic [1:0] CMD_STOP   = 2'd2;

  localparam logic [1:0] KIND_BUTTON = 2'd0;
  localparam logic [1:0] KIND_LEFT   = 2'd1;
  localparam logic [1:0] KIND_RIGHT  = 2'd2;

  localparam logic [7:0] STICK_REPORT_ID = 8'h01;
  localparam logic [6:0] STICK_MIN_LEN   = 7'd5;
  localparam logic [6:0] DEAD_ZONE_RST   = 7'd3;

  // status of the button scanner at its current bit
  typedef struct packed {
    logic hit;      // current bit changed
    logic pressed;  // new state of current bit
    logic more;     // changed bits remain above current bit
    logic at_end;   // current bit is the top one
  } scan_stat_t;

endpackage
`default_nettype wire

// ----- src/controller_change_event_recorder_core.sv -----
// Top level of the controller change-event recorder.
// Usage:
//   Input channel s_*: one item per command. s_tuser carries cmd (start,
//   report, stop); s_tdata carries the timestamp, button vector, report id,
//   report length and the four raw stick bytes.
//   Output channel m_*: change events. m_tuser is the event kind, m_tlast
//   marks the final event caused by a report.
//   cfg_we/cfg_data write the stick dead zone (reset value 3).
// Sequence:
//   A start, stop or ignored item leaves s_tready high. A report is
//   accepted, then the bit-serial scanner visits one button per cycle
//   unless a changed button waits on the output, then one slot each for the
//   left and right stick. Each emitted event appears on m_* in the cycle
//   after its slot emits it.
// Reset: recording off, recorded buttons and sticks cleared, output empty.
// Stall: the output register holds its item while m_tready is low and the
//   scanner waits on a changed button; s_tready stays low until the report
//   is fully emitted.
`default_nettype none
module controller_change_event_recorder_core
  import cce_pkg::*;
#(
  parameter int NUM_BUTTONS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // stick_dead_zone register
  input  wire logic        cfg_we,
  input  wire logic [6:0]  cfg_data,
  // input items
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // [31:0] timestamp_ms, [47:32] buttons, [55:48] report_id, [62:56] report_len,
  // [70:63] left_x_raw, [78:71] left_y_raw, [86:79] right_x_raw,
  // [94:87] right_y_raw, [95] zero
  input  wire logic [95:0] s_tdata,
  // [1:0] cmd
  input  wire logic [1:0]  s_tuser,
  // output events
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // [3:0] button_index, [4] pressed, [12:5] axis_x, [20:13] axis_y,
  // [36:21] wait_ms, [39:37] zero
  output logic [39:0]      m_tdata,
  // [1:0] event_kind
  output logic [1:0]       m_tuser,
  // last_of_report
  output logic             m_tlast
);

  localparam int NB = (NUM_BUTTONS < 16) ? NUM_BUTTONS : 16;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_LEFT  = 2'd2;
  localparam logic [1:0] ST_RIGHT = 2'd3;

  // input field split
  logic [31:0]   in_ts;
  logic [NB-1:0] in_btn;
  logic [7:0]    in_id;
  logic [6:0]    in_len;
  assign in_ts  = s_tdata[31:0];
  assign in_btn = s_tdata[32 +: NB];
  assign in_id  = s_tdata[55:48];
  assign in_len = s_tdata[62:56];

  logic [1:0]    state;
  logic [6:0]    dead_zone;
  logic          recording;
  logic [NB-1:0] prev_buttons;
  logic [31:0]   last_time;
  logic          first_pend;
  logic          l_pend, r_pend;
  logic [15:0]   dly;
  logic          lead;           // next event emitted is the first of the report

  logic          acc, rpt_acc, stick_en, l_chg, r_chg, any_evt;
  logic [NB-1:0] diff;
  logic [31:0]   dt;
  logic [15:0]   dt_sat;
  logic [7:0]    plx, ply, prx, pry;
  scan_stat_t    sst;
  logic [3:0]    sidx;

  logic          slot, emit, adv;
  logic [1:0]    ev_kind;
  logic [3:0]    ev_idx;
  logic          ev_pr, ev_last;
  logic [7:0]    ev_x, ev_y;

  assign s_tready = (state == ST_IDLE);
  assign acc      = s_tvalid && s_tready;
  assign rpt_acc  = acc && (s_tuser == CMD_REPORT) && recording;
  assign stick_en = (in_id == STICK_REPORT_ID) && (in_len >= STICK_MIN_LEN);
  assign diff     = in_btn ^ prev_buttons;
  assign any_evt  = (diff != '0) || l_chg || r_chg;
  assign dt       = in_ts - last_time;
  assign dt_sat   = (dt[31:16] != 16'd0) ? 16'hFFFF : dt[15:0];

  cce_bit_scan #(.NB(NB)) u_scan (
    .clk   (clk),
    .rst   (rst),
    .load  (rpt_acc),
    .shift (adv && (state == ST_SCAN)),
    .diff  (diff),
    .cur   (in_btn),
    .stat  (sst),
    .idx   (sidx)
  );

  cce_stick_cmp u_stick (
    .clk       (clk),
    .rst       (rst),
    .clear     (acc && (s_tuser == CMD_START)),
    .update    (rpt_acc),
    .en        (stick_en),
    .dead_zone (dead_zone),
    .lx_raw    (s_tdata[70:63]),
    .ly_raw    (s_tdata[78:71]),
    .rx_raw    (s_tdata[86:79]),
    .ry_raw    (s_tdata[94:87]),
    .l_chg     (l_chg),
    .r_chg     (r_chg),
    .prev_lx   (plx),
    .prev_ly   (ply),
    .prev_rx   (prx),
    .prev_ry   (pry)
  );

  // event sequencing: a slot advances when it has nothing to send or the
  // output register can take its event
  assign slot = !m_tvalid || m_tready;

  always_comb begin
    emit    = 1'b0;
    adv     = 1'b0;
    ev_kind = KIND_BUTTON;
    ev_idx  = 4'd0;
    ev_pr   = 1'b0;
    ev_last = 1'b0;
    ev_x    = 8'd0;
    ev_y    = 8'd0;
    unique case (state)
      ST_SCAN: begin
        emit    = sst.hit && slot;
        adv     = !sst.hit || slot;
        ev_idx  = sidx;
        ev_pr   = sst.pressed;
        ev_last = !sst.more && !l_pend && !r_pend;
      end
      ST_LEFT: begin
        emit    = l_pend && slot;
        adv     = !l_pend || slot;
        ev_kind = KIND_LEFT;
        ev_last = !r_pend;
        ev_x    = plx;
        ev_y    = ply;
      end
      ST_RIGHT: begin
        emit    = r_pend && slot;
        adv     = !r_pend || slot;
        ev_kind = KIND_RIGHT;
        ev_last = 1'b1;
        ev_x    = prx;
        ev_y    = pry;
      end
      default: begin
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      dead_zone    <= DEAD_ZONE_RST;
      recording    <= 1'b0;
      prev_buttons <= '0;
      last_time    <= '0;
      first_pend   <= 1'b1;
      l_pend       <= 1'b0;
      r_pend       <= 1'b0;
      lead         <= 1'b0;
      m_tvalid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        dead_zone <= cfg_data;
      end
      if (acc) begin
        unique case (s_tuser)
          CMD_START: begin
            recording    <= 1'b1;
            prev_buttons <= '0;
            last_time    <= in_ts;
            first_pend   <= 1'b1;
          end
          CMD_STOP: begin
            recording <= 1'b0;
          end
          CMD_REPORT: begin
            if (recording) begin
              prev_buttons <= in_btn;
              l_pend       <= l_chg;
              r_pend       <= r_chg;
              lead         <= 1'b1;
              state        <= ST_SCAN;
              if (any_evt) begin
                last_time  <= in_ts;
                first_pend <= 1'b0;
              end
            end
          end
          default: begin
          end
        endcase
      end
      unique case (state)
        ST_SCAN:  if (adv && sst.at_end) state <= ST_LEFT;
        ST_LEFT:  if (adv) state <= ST_RIGHT;
        ST_RIGHT: if (adv) state <= ST_IDLE;
        default: begin
        end
      endcase
      if (emit) begin
        lead     <= 1'b0;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (rpt_acc) begin
      dly <= first_pend ? 16'd0 : dt_sat;
    end
    if (emit) begin
      m_tuser <= ev_kind;
      m_tlast <= ev_last;
      m_tdata <= {3'd0, (lead ? dly : 16'd0), ev_y, ev_x, ev_pr, ev_idx};
    end
  end

endmodule
`default_nettype wire

// ----- src/cce_bit_scan.sv -----
// Bit-serial scanner over the changed-button vector, one button per cycle while shift is asserted.
`default_nettype none
module cce_bit_scan
  import cce_pkg::*;
#(
  parameter int NB = 16
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          load,
  input  wire logic          shift,
  input  wire logic [NB-1:0] diff,
  input  wire logic [NB-1:0] cur,
  output scan_stat_t         stat,
  output logic [3:0]         idx
);

  localparam int IW = (NB > 1) ? $clog2(NB) : 1;

  logic [NB-1:0] dsr;
  logic [NB-1:0] csr;
  logic [IW-1:0] cnt;

  always_ff @(posedge clk) begin
    if (load) begin
      dsr <= diff;
      csr <= cur;
    end else if (shift) begin
      dsr <= dsr >> 1;
      csr <= csr >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (load) begin
      cnt <= '0;
    end else if (shift) begin
      cnt <= cnt + IW'(1);
    end
  end

  always_comb begin
    stat.hit     = dsr[0];
    stat.pressed = csr[0];
    stat.more    = (dsr >> 1) != '0;
    stat.at_end  = (cnt == IW'(NB - 1));
    idx          = 4'(cnt);
  end

endmodule
`default_nettype wire

// ----- src/cce_stick_cmp.sv -----
// Dead-zone snapping of both sticks and the recorded stick positions.
`default_nettype none
module cce_stick_cmp
  import cce_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       clear,
  input  wire logic       update,
  input  wire logic       en,
  input  wire logic [6:0] dead_zone,
  input  wire logic [7:0] lx_raw,
  input  wire logic [7:0] ly_raw,
  input  wire logic [7:0] rx_raw,
  input  wire logic [7:0] ry_raw,
  output logic            l_chg,
  output logic            r_chg,
  output logic [7:0]      prev_lx,
  output logic [7:0]      prev_ly,
  output logic [7:0]      prev_rx,
  output logic [7:0]      prev_ry
);

  function automatic logic [7:0] snap(input logic [7:0] raw, input logic [6:0] dz);
    logic [7:0] off;
    logic [7:0] mag;
    off = raw ^ 8'h80;
    mag = off[7] ? (8'd0 - off) : off;
    return (mag <= {1'b0, dz}) ? 8'd0 : off;
  endfunction

  logic [7:0] lx, ly, rx, ry;

  always_comb begin
    lx    = snap(lx_raw, dead_zone);
    ly    = snap(ly_raw, dead_zone);
    rx    = snap(rx_raw, dead_zone);
    ry    = snap(ry_raw, dead_zone);
    l_chg = en && ((lx != prev_lx) || (ly != prev_ly));
    r_chg = en && ((rx != prev_rx) || (ry != prev_ry));
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      prev_lx <= '0;
      prev_ly <= '0;
      prev_rx <= '0;
      prev_ry <= '0;
    end else if (update) begin
      if (l_chg) begin
        prev_lx <= lx;
        prev_ly <= ly;
      end
      if (r_chg) begin
        prev_rx <= rx;
        prev_ry <= ry;
      end
    end
  end

endmodule
`default_nettype wire
